### rtl/core/fle_pkg.sv
package fle_pkg;

    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int PAT_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 4'd1;

    localparam logic [PAT_W-1:0] HEADER_RESET  = 32'h4546_2324;
    localparam logic [PAT_W-1:0] TRAILER_RESET = 32'h2423_4645;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_NONE  = 2'd2
    } status_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

### rtl/core/fle_cell.sv
module fle_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fle_pkg::cell_ctrl_t              ctrl,
    input  logic [fle_pkg::BYTE_W-1:0]       shift_in,
    input  logic [fle_pkg::BYTE_W-1:0]       load_in,
    output logic [fle_pkg::BYTE_W-1:0]       q
);

    logic [fle_pkg::BYTE_W-1:0] q_reg;
    logic [fle_pkg::BYTE_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.clr)
        begin
            q_next = '0;
        end
        else if (ctrl.load)
        begin
            q_next = load_in;
        end
        else if (ctrl.shift)
        begin
            q_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### rtl/core/fixed_length_frame_extractor_unit.sv
// Fixed-length frame extractor: takes one package byte per beat into a sliding window of
// FRAME_LEN cells and, when the window opens with header_pattern and closes with
// trailer_pattern, copies it in parallel into a frame buffer chain that sends the FRAME_LEN
// bytes out one per output beat, oldest first, frame_last on the final byte. Matches within
// FRAME_LEN-1 bytes after a frame are ignored. The final byte of a package (package_end)
// yields one status beat after any frame bytes of that package: success, too short, or none
// found; the window and counters then clear, the patterns stay. Input runs at one byte per
// cycle; since a frame cannot follow sooner than FRAME_LEN bytes, the buffer drains in time
// and input is held only while the output side is stalled or a status beat still waits
// behind frame bytes (a frame ending a package gives FRAME_LEN+1 result beats). The
// configuration port always accepts; index 0 writes the header, 1 the trailer, others are
// dropped.
module fixed_length_frame_extractor_unit #(
    parameter int FRAME_LEN = 45
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [fle_pkg::BYTE_W-1:0]         in_byte,
    input  logic                               package_end,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               is_status,
    output logic [fle_pkg::BYTE_W-1:0]         frame_byte,
    output logic                               frame_last,
    output logic [1:0]                         status,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fle_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fle_pkg::PAT_W-1:0]          cfg_data
);

    localparam int CNT_W  = $clog2(FRAME_LEN + 1);
    localparam int SKIP_W = $clog2(FRAME_LEN);

    logic [fle_pkg::PAT_W-1:0] header_reg;
    logic [fle_pkg::PAT_W-1:0] trailer_reg;

    logic [fle_pkg::BYTE_W-1:0] win_q  [FRAME_LEN];
    logic [fle_pkg::BYTE_W-1:0] win_sh [FRAME_LEN];
    logic [fle_pkg::BYTE_W-1:0] fb_q   [FRAME_LEN];
    logic [fle_pkg::BYTE_W-1:0] fb_sh  [FRAME_LEN];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SKIP_W-1:0] skip_reg;
    logic [SKIP_W-1:0] skip_next;
    logic              found_reg;
    logic              found_next;
    logic [CNT_W-1:0]  frame_cnt_reg;
    logic [CNT_W-1:0]  frame_cnt_next;
    logic              st_valid_reg;
    logic              st_valid_next;
    fle_pkg::status_t  st_code_reg;
    fle_pkg::status_t  st_code_next;

    logic              in_fire;
    logic              out_fire;
    logic              frame_fire;
    logic              st_fire;
    logic              frame_free;
    logic              st_free;
    logic              may_frame;
    logic [CNT_W-1:0]  count_inc;
    logic              hdr_hit;
    logic              trl_hit;
    logic              match;
    logic              frame_load;

    fle_pkg::cell_ctrl_t win_ctrl;
    fle_pkg::cell_ctrl_t fb_ctrl;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= fle_pkg::HEADER_RESET;
            trailer_reg <= fle_pkg::TRAILER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fle_pkg::REG_HEADER:  header_reg  <= cfg_data;
                fle_pkg::REG_TRAILER: trailer_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // cell chains
    genvar k;
    generate
        for (k = 0; k < FRAME_LEN; k++)
        begin : g_cells
            if (k == FRAME_LEN - 1)
            begin : g_tail
                assign win_sh[k] = in_byte;
                assign fb_sh[k]  = '0;
            end
            else
            begin : g_body
                assign win_sh[k] = win_q[k+1];
                assign fb_sh[k]  = fb_q[k+1];
            end

            fle_cell u_win (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (win_ctrl),
                .shift_in (win_sh[k]),
                .load_in  ('0),
                .q        (win_q[k])
            );

            fle_cell u_fb (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (fb_ctrl),
                .shift_in (fb_sh[k]),
                .load_in  (win_sh[k]),
                .q        (fb_q[k])
            );
        end
    endgenerate

    // match on the window as it stands after this beat
    assign hdr_hit = ({win_sh[0], win_sh[1], win_sh[2], win_sh[3]} == header_reg);
    assign trl_hit = ({win_sh[FRAME_LEN-4], win_sh[FRAME_LEN-3],
                       win_sh[FRAME_LEN-2], win_sh[FRAME_LEN-1]} == trailer_reg);

    assign count_inc = (count_reg == CNT_W'(FRAME_LEN)) ? count_reg : count_reg + CNT_W'(1);
    assign may_frame = (skip_reg == '0) && (count_reg >= CNT_W'(FRAME_LEN - 1));
    assign match     = may_frame && hdr_hit && trl_hit;

    // output side
    assign out_valid  = (frame_cnt_reg != '0) || st_valid_reg;
    assign out_fire   = out_valid && !out_stall;
    assign frame_fire = out_fire && (frame_cnt_reg != '0);
    assign st_fire    = out_fire && (frame_cnt_reg == '0) && st_valid_reg;
    assign frame_free = (frame_cnt_reg == '0) || ((frame_cnt_reg == CNT_W'(1)) && out_fire);
    assign st_free    = !st_valid_reg || st_fire;

    assign in_stall = (may_frame && !(frame_free && st_free)) || (package_end && !st_free);
    assign in_fire  = in_valid && !in_stall;

    assign frame_load = in_fire && match;

    always_comb
    begin
        win_ctrl.clr   = in_fire && package_end;
        win_ctrl.load  = 1'b0;
        win_ctrl.shift = in_fire;
        fb_ctrl.clr    = 1'b0;
        fb_ctrl.load   = frame_load;
        fb_ctrl.shift  = frame_fire;
    end

    always_comb
    begin
        count_next     = count_reg;
        skip_next      = skip_reg;
        found_next     = found_reg;
        frame_cnt_next = frame_cnt_reg;
        st_valid_next  = st_valid_reg;
        st_code_next   = st_code_reg;

        if (frame_load)
        begin
            frame_cnt_next = CNT_W'(FRAME_LEN);
        end
        else if (frame_fire)
        begin
            frame_cnt_next = frame_cnt_reg - CNT_W'(1);
        end

        if (st_fire)
        begin
            st_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            count_next = count_inc;
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - SKIP_W'(1);
            end
            else if (match)
            begin
                skip_next  = SKIP_W'(FRAME_LEN - 1);
                found_next = 1'b1;
            end

            if (package_end)
            begin
                st_valid_next = 1'b1;
                if (count_inc < CNT_W'(FRAME_LEN))
                begin
                    st_code_next = fle_pkg::STATUS_SHORT;
                end
                else if (found_reg || match)
                begin
                    st_code_next = fle_pkg::STATUS_OK;
                end
                else
                begin
                    st_code_next = fle_pkg::STATUS_NONE;
                end
                count_next = '0;
                skip_next  = '0;
                found_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            skip_reg      <= '0;
            found_reg     <= 1'b0;
            frame_cnt_reg <= '0;
            st_valid_reg  <= 1'b0;
            st_code_reg   <= fle_pkg::STATUS_OK;
        end
        else
        begin
            count_reg     <= count_next;
            skip_reg      <= skip_next;
            found_reg     <= found_next;
            frame_cnt_reg <= frame_cnt_next;
            st_valid_reg  <= st_valid_next;
            st_code_reg   <= st_code_next;
        end
    end

    assign is_status  = (frame_cnt_reg == '0);
    assign frame_byte = (frame_cnt_reg != '0) ? fb_q[0] : '0;
    assign frame_last = (frame_cnt_reg == CNT_W'(1));
    assign status     = (frame_cnt_reg != '0) ? fle_pkg::STATUS_OK : st_code_reg;

`ifndef SYNTH
    a_frame_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_cnt_reg <= CNT_W'(FRAME_LEN))
        else $error("frame count out of range");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        frame_load |=> (frame_cnt_reg == CNT_W'(FRAME_LEN)))
        else $error("frame load did not fill the buffer");

    a_no_load_over_status: assert property (@(posedge clk) disable iff (!rst_n)
        frame_load |-> (!st_valid_reg || st_fire))
        else $error("frame loaded ahead of a waiting status beat");

    a_skip_blocks_match: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != '0) |-> !match)
        else $error("match taken during skip");
`endif

endmodule
